### rtl/bdf_pkg.sv
// ----------------------------------------------------------------------------
// bdf_pkg
// Shared types, sizes and constants of the binary density filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bdf_pkg;

  // Frame geometry limits.
  localparam int unsigned MAX_WIDTH   = 640;
  localparam int unsigned MAX_HEIGHT  = 480;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // Window geometry: a 6x6 window at offsets -3..+2 and a 10-pixel margin.
  localparam int unsigned HALF_WIN    = 3;
  localparam int unsigned EDGE_MARGIN = 10;

  // Field and register widths.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FW_W       = 10;
  localparam int unsigned FH_W       = 9;
  localparam int unsigned PL_W       = 19;
  localparam int unsigned LT_W       = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;
  localparam int unsigned DENS_W     = 6;
  localparam int unsigned HCNT_W     = 3;
  localparam int unsigned CMP_W      = 16;

  // Internal widths.
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned SIZE_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(STORE_DEPTH + HALF_WIN * MAX_WIDTH + 1);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + HALF_WIN);

  // Reset values of the registers.
  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
  localparam logic [PL_W-1:0] PL_RESET = PL_W'(5000);
  localparam logic [LT_W-1:0] LT_RESET = LT_W'(120);

  localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
  localparam logic [PIX_W-1:0] PIX_NONE = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_POINT_LIMIT,
    REG_LEVEL_THRESHOLD
  } cfg_reg_e;

  // One element of the sliding window line.
  typedef struct packed {
    logic [HCNT_W-1:0] cnt;
    logic              flag;
  } win_ent_t;

  function automatic logic [COL_W-1:0] eff_width(logic [FW_W-1:0] fw);
    logic [COL_W-1:0] w;
    if (32'(fw) > MAX_WIDTH) begin
      w = COL_W'(MAX_WIDTH);
    end else if (fw == '0) begin
      w = COL_W'(1);
    end else begin
      w = COL_W'(fw);
    end
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(logic [FH_W-1:0] fh);
    logic [ROW_W-1:0] h;
    if (32'(fh) > MAX_HEIGHT) begin
      h = ROW_W'(MAX_HEIGHT);
    end else if (fh == '0) begin
      h = ROW_W'(1);
    end else begin
      h = ROW_W'(fh);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

### rtl/binary_density_filter_core.sv
// ----------------------------------------------------------------------------
// binary_density_filter_core
// Stores a binary mask frame, decides it on its last pixel and reads back
// either the stored frame or its thresholded 6x6 window density.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Word
//  cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//  in        in         in_valid_i / in_stall_o   mode_i, in_pixel_i
//  out       out        out_valid_o / out_stall_i out_pixel_o, out_last_o
//
//  Loads and reads are accepted back to back while in_stall_o is low; a read
//  result passes through one frame-store read stage and then the output
//  register. After the last load, the input stalls until the pending read
//  drains; if the frame falls below the point limit, it also stalls through
//  a row pass and a column pass, both bound by one memory access per cycle.
//  Reset clears the control state; the frame store and work store are not
//  cleared. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_density_filter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bdf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bdf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [bdf_pkg::PIX_W-1:0]       in_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bdf_pkg::PIX_W-1:0]       out_pixel_o,
  output logic                            out_last_o
);
  import bdf_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_P1,
    ST_P2
  } state_e;

  localparam int unsigned WIN_DEPTH = 2 * HALF_WIN + 1;

  // Memories.
  logic [PIX_W-1:0]  frame_mem [STORE_DEPTH];
  logic [DENS_W-1:0] work_mem  [STORE_DEPTH];
  logic [PIX_W-1:0]  fm_rdata_q;
  logic [DENS_W-1:0] wm_rdata_q;

  // Configuration.
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [PL_W-1:0] pl_q;
  logic [LT_W-1:0] lt_q;

  // Control state.
  state_e            state_q;
  logic [SIZE_W-1:0] load_pos_q, read_pos_q, nz_total_q, dec_size_q, size_l_q;
  logic              pend_pass_q, pass_q;
  logic [DENS_W-1:0] peak_q;
  logic [COL_W-1:0]  w_l_q;
  logic [ROW_W-1:0]  h_l_q;
  logic [IDX_W-1:0]  w3_l_q;

  // Pass issue counters and pipeline.
  logic              iss_on_q;
  logic [IDX_W-1:0]  idx_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              m1_v_q, m1_inr_q, m1_mg_q, m1_wok_q;
  logic [IDX_W-1:0]  m1_waddr_q;
  win_ent_t          sh_q [WIN_DEPTH];
  logic              sh_v_q, sh_wok_q;
  logic [IDX_W-1:0]  sh_waddr_q;

  // Read path.
  logic              s1_v_q, s1_last_q, s1_in_q;
  logic              out_valid_q, out_last_q;
  logic [PIX_W-1:0]  out_pixel_q;

  // Combinational signals.
  logic [COL_W-1:0]  eff_w;
  logic [ROW_W-1:0]  eff_h;
  logic [SIZE_W-1:0] size, lpos, rpos, nz_new;
  logic              l_last, r_last;
  logic              acc, acc_ld, acc_rd, out_free, s1_adv;
  logic              fm_re, wm_re, wm_we;
  logic [ADDR_W-1:0] fm_raddr, wm_raddr;
  logic [DENS_W-1:0] wm_wdata;
  logic              iss_inr, iss_mg, iss_wok;
  logic [IDX_W-1:0]  iss_waddr;
  win_ent_t          ent_new;
  logic [DENS_W-1:0] win_sum;
  logic              win_any;
  logic [CMP_W-1:0]  cmp_lhs, cmp_rhs;
  logic [PIX_W-1:0]  out_pix_d;

  assign eff_w = eff_width(fw_q);
  assign eff_h = eff_height(fh_q);
  assign size  = SIZE_W'(SIZE_W'(eff_w) * SIZE_W'(eff_h));

  assign lpos   = (load_pos_q < size) ? load_pos_q : SIZE_W'(size - 1'b1);
  assign l_last = (SIZE_W'(lpos + 1'b1) >= size);
  assign rpos   = (read_pos_q < size) ? read_pos_q : SIZE_W'(size - 1'b1);
  assign r_last = (SIZE_W'(rpos + 1'b1) >= size);
  assign nz_new = nz_total_q + SIZE_W'(in_pixel_i != PIX_NONE);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_v_q || out_free;
  assign in_stall_o = (state_q != ST_RUN) || !s1_adv;
  assign acc        = in_valid_i && !in_stall_o;
  assign acc_ld     = acc && !mode_i;
  assign acc_rd     = acc && mode_i;

  assign fm_re    = acc_rd || ((state_q == ST_P1) && iss_on_q);
  assign fm_raddr = (state_q == ST_P1) ? idx_q[ADDR_W-1:0] : rpos[ADDR_W-1:0];
  assign wm_re    = acc_rd || ((state_q == ST_P2) && iss_on_q);
  assign wm_raddr = (state_q == ST_P2) ? idx_q[ADDR_W-1:0] : rpos[ADDR_W-1:0];

  // Tags of the element issued this cycle: in frame, inside the margin,
  // and whether its window center falls on a real pixel.
  always_comb begin
    if (state_q == ST_P1) begin
      iss_inr   = (idx_q < IDX_W'(size_l_q));
      iss_mg    = (col_q >= COL_W'(EDGE_MARGIN)) &&
                  ((COL_W + 1)'(col_q) + (COL_W + 1)'(EDGE_MARGIN) <= (COL_W + 1)'(w_l_q));
      iss_wok   = (idx_q >= IDX_W'(HALF_WIN));
      iss_waddr = IDX_W'(idx_q - IDX_W'(HALF_WIN));
    end else begin
      iss_inr   = (row_q < h_l_q);
      iss_mg    = (row_q >= ROW_W'(EDGE_MARGIN)) &&
                  ((ROW_W + 1)'(row_q) + (ROW_W + 1)'(EDGE_MARGIN) <= (ROW_W + 1)'(h_l_q));
      iss_wok   = (row_q >= ROW_W'(HALF_WIN));
      iss_waddr = IDX_W'(idx_q - w3_l_q);
    end
  end

  // The row pass counts full pixels and margin-qualified set pixels; the
  // column pass takes the row results back out of the work store.
  always_comb begin
    if (state_q == ST_P1) begin
      ent_new.cnt  = HCNT_W'(fm_rdata_q == PIX_FULL);
      ent_new.flag = (fm_rdata_q != PIX_NONE);
    end else begin
      ent_new.cnt  = wm_rdata_q[HCNT_W:1];
      ent_new.flag = wm_rdata_q[0];
    end
    if (!m1_inr_q) begin
      ent_new.cnt = '0;
    end
    ent_new.flag = ent_new.flag && m1_inr_q && m1_mg_q;
  end

  // The center sits HALF_WIN behind the newest element: counts cover
  // offsets -3..+2, set pixels that mark coverage cover offsets -2..+3.
  always_comb begin
    win_sum = '0;
    win_any = 1'b0;
    for (int k = 1; k <= 2 * HALF_WIN; k++) begin
      win_sum = win_sum + DENS_W'(sh_q[k].cnt);
    end
    for (int k = 0; k < 2 * HALF_WIN; k++) begin
      win_any = win_any | sh_q[k].flag;
    end
  end

  assign wm_we    = sh_v_q && sh_wok_q;
  assign wm_wdata = (state_q == ST_P1) ? DENS_W'({win_sum[HCNT_W-1:0], win_any}) :
                    (win_any ? win_sum : '0);

  // 255 where 510*density > (2*threshold+1)*peak.
  assign cmp_lhs = CMP_W'(s1_in_q ? wm_rdata_q : '0) * CMP_W'(2 * PIX_FULL);
  assign cmp_rhs = CMP_W'((CMP_W'(lt_q) << 1) + 1'b1) * CMP_W'(peak_q);
  assign out_pix_d = pass_q ? fm_rdata_q : ((cmp_lhs > cmp_rhs) ? PIX_FULL : PIX_NONE);

  always_ff @(posedge clk_i) begin
    if (acc_ld) begin
      frame_mem[lpos[ADDR_W-1:0]] <= in_pixel_i;
    end
    if (fm_re) begin
      fm_rdata_q <= frame_mem[fm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      work_mem[sh_waddr_q[ADDR_W-1:0]] <= wm_wdata;
    end
    if (wm_re) begin
      wm_rdata_q <= work_mem[wm_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= FW_RESET;
      fh_q        <= FH_RESET;
      pl_q        <= PL_RESET;
      lt_q        <= LT_RESET;
      state_q     <= ST_RUN;
      load_pos_q  <= '0;
      read_pos_q  <= '0;
      nz_total_q  <= '0;
      dec_size_q  <= '0;
      size_l_q    <= '0;
      pend_pass_q <= 1'b0;
      pass_q      <= 1'b0;
      peak_q      <= '0;
      w_l_q       <= '0;
      h_l_q       <= '0;
      w3_l_q      <= '0;
      iss_on_q    <= 1'b0;
      idx_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      m1_v_q      <= 1'b0;
      m1_inr_q    <= 1'b0;
      m1_mg_q     <= 1'b0;
      m1_wok_q    <= 1'b0;
      m1_waddr_q  <= '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
        sh_q[k] <= '0;
      end
      sh_v_q      <= 1'b0;
      sh_wok_q    <= 1'b0;
      sh_waddr_q  <= '0;
      s1_v_q      <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_in_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_pixel_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_WIDTH:     fw_q <= cfg_data_i[FW_W-1:0];
          REG_FRAME_HEIGHT:    fh_q <= cfg_data_i[FH_W-1:0];
          REG_POINT_LIMIT:     pl_q <= cfg_data_i[PL_W-1:0];
          REG_LEVEL_THRESHOLD: lt_q <= cfg_data_i[LT_W-1:0];
        endcase
      end

      // Pass pipeline: memory read stage, then the window line.
      m1_v_q     <= iss_on_q && ((state_q == ST_P1) || (state_q == ST_P2));
      m1_inr_q   <= iss_inr;
      m1_mg_q    <= iss_mg;
      m1_wok_q   <= iss_wok;
      m1_waddr_q <= iss_waddr;
      sh_v_q     <= m1_v_q;
      if (m1_v_q) begin
        sh_q[0] <= ent_new;
        for (int k = 1; k < WIN_DEPTH; k++) begin
          sh_q[k] <= sh_q[k-1];
        end
        sh_wok_q   <= m1_wok_q;
        sh_waddr_q <= m1_waddr_q;
      end
      if (wm_we && (state_q == ST_P2) && win_any && (win_sum > peak_q)) begin
        peak_q <= win_sum;
      end

      unique case (state_q)
        ST_RUN: begin
          if (acc_ld) begin
            if (l_last) begin
              load_pos_q  <= '0;
              nz_total_q  <= '0;
              pend_pass_q <= (nz_new >= SIZE_W'(pl_q)) && (32'(pl_q) <= STORE_DEPTH)
                             || (32'(nz_new) >= 32'(pl_q));
              size_l_q    <= size;
              w_l_q       <= eff_w;
              h_l_q       <= eff_h;
              w3_l_q      <= IDX_W'(IDX_W'(eff_w) * IDX_W'(HALF_WIN));
              state_q     <= ST_DRAIN;
            end else begin
              load_pos_q <= SIZE_W'(lpos + 1'b1);
              nz_total_q <= nz_new;
            end
          end
        end
        ST_DRAIN: begin
          if (!s1_v_q) begin
            pass_q <= pend_pass_q;
            peak_q <= '0;
            if (pend_pass_q) begin
              dec_size_q <= '0;
              state_q    <= ST_RUN;
            end else begin
              dec_size_q <= size_l_q;
              idx_q      <= '0;
              col_q      <= '0;
              row_q      <= '0;
              iss_on_q   <= 1'b1;
              state_q    <= ST_P1;
            end
          end
        end
        ST_P1: begin
          if (iss_on_q) begin
            if (idx_q == IDX_W'(IDX_W'(size_l_q) + IDX_W'(HALF_WIN - 1))) begin
              iss_on_q <= 1'b0;
            end else begin
              idx_q <= IDX_W'(idx_q + 1'b1);
              col_q <= (col_q == COL_W'(w_l_q - 1'b1)) ? '0 : COL_W'(col_q + 1'b1);
            end
          end else if (!m1_v_q && !sh_v_q) begin
            idx_q    <= '0;
            col_q    <= '0;
            row_q    <= '0;
            iss_on_q <= 1'b1;
            state_q  <= ST_P2;
          end
        end
        ST_P2: begin
          if (iss_on_q) begin
            if (row_q == ROW_W'(h_l_q + ROW_W'(HALF_WIN - 1))) begin
              if (col_q == COL_W'(w_l_q - 1'b1)) begin
                iss_on_q <= 1'b0;
              end else begin
                col_q <= COL_W'(col_q + 1'b1);
                row_q <= '0;
                idx_q <= IDX_W'(IDX_W'(col_q) + 1'b1);
              end
            end else begin
              row_q <= ROW_W'(row_q + 1'b1);
              idx_q <= IDX_W'(idx_q + IDX_W'(w_l_q));
            end
          end else if (!m1_v_q && !sh_v_q) begin
            state_q <= ST_RUN;
          end
        end
      endcase

      // Read path: one read stage, then the output register.
      if (s1_adv) begin
        s1_v_q <= acc_rd;
        if (acc_rd) begin
          s1_last_q  <= r_last;
          s1_in_q    <= (rpos < dec_size_q);
          read_pos_q <= r_last ? '0 : SIZE_W'(rpos + 1'b1);
        end
      end
      if (out_free) begin
        out_valid_q <= s1_v_q;
        if (s1_v_q) begin
          out_pixel_q <= out_pix_d;
          out_last_q  <= s1_last_q;
        end
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
